[src/tlac_pkg.sv]
// ----------------------------------------------------------------------------
// tlac_pkg
// Shared constants for the tank level alarm controller: register map,
// register reset values, measurement status codes and gauge constants.
// ----------------------------------------------------------------------------
package tlac_pkg;

	// serial datapath digit width
	localparam int DIGIT_W = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_DIST  = 3'd0,
		REG_EMPTY_DIST = 3'd1,
		REG_DEBOUNCE   = 3'd2,
		REG_ALERT_TO   = 3'd3,
		REG_OFFLINE_TO = 3'd4,
		REG_LED_HALF   = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [15:0] RST_FULL_DIST  = 16'd20;
	localparam logic [15:0] RST_EMPTY_DIST = 16'd150;
	localparam logic [23:0] RST_DEBOUNCE   = 24'd30000;
	localparam logic [31:0] RST_ALERT_TO   = 32'd15000000;
	localparam logic [31:0] RST_OFFLINE_TO = 32'd15000000;
	localparam logic [23:0] RST_LED_HALF   = 24'd500000;

	// measurement status codes
	localparam logic [7:0] STAT_DIST = 8'd1;
	localparam logic [7:0] STAT_FULL = 8'd2;

	// gauge
	localparam int          PCT_W    = 7;
	localparam logic [6:0]  PCT_FULL = 7'd100;
	localparam logic [7:0]  PCT_NONE = 8'd255;

endpackage

[src/tank_level_alarm_controller.sv]
// ----------------------------------------------------------------------------
// tank_level_alarm_controller
// Polling-pass controller: heartbeat LED, button debounce, tank-full alert
// with silence, fill gauge and transmitter offline detection.
// ----------------------------------------------------------------------------
//
//  channel   handshake              direction  word
//  --------  ---------------------  ---------  ------------------------------
//  input     in_valid / in_ready    in         now_time, meas_valid,
//                                              meas_status, echo_dist,
//                                              switch_raw
//  output    out_valid / out_ready  out        led_on, buzzer_on, gauge_update,
//                                              gauge_percent, offline_event,
//                                              offline_flag
//  config    cfg_we                 in         cfg_index, cfg_wdata
//
// The result is registered when the word commits: all time differences and
// the next LED deadline run through a 4-bit serial adder/subtractor, one
// digit per cycle, then the commit updates state and the result. in_ready
// returns the cycle after the commit. The percent divider (7 restoring
// steps) runs alongside the time digits. A new word is taken once the
// previous one has committed; a result still waiting in the output
// register only holds the commit cycle.
// Reset is asynchronous, active low, and brings control, state, config and
// output registers to defaults; the serial datapath is not reset.

module tank_level_alarm_controller #(
	parameter int TIME_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config
	input  logic                            cfg_we,
	input  logic [tlac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input word
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [TIME_BITS-1:0]            now_time,
	input  logic                            meas_valid,
	input  logic [7:0]                      meas_status,
	input  logic [15:0]                     echo_dist,
	input  logic                            switch_raw,
	// output word
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            led_on,
	output logic                            buzzer_on,
	output logic                            gauge_update,
	output logic [tlac_pkg::PCT_W-1:0]      gauge_percent,
	output logic                            offline_event,
	output logic                            offline_flag
);
	import tlac_pkg::*;

	localparam int DW       = DIGIT_W;
	localparam int NDIG     = (TIME_BITS + DW - 1) / DW;
	localparam int W        = NDIG * DW;
	localparam int CW       = $clog2(NDIG);
	localparam int SIGN_DIG = (TIME_BITS - 1) / DW;
	localparam int SIGN_BIT = (TIME_BITS - 1) % DW;
	localparam logic [W-1:0]  TMASK_W  = W'({TIME_BITS{1'b1}});
	localparam logic [CW-1:0] CNT_LAST = CW'(NDIG - 1);
	localparam logic [CW-1:0] CNT_SIGN = CW'(SIGN_DIG);
	localparam logic [CW-1:0] DIV_LAST = CW'(PCT_W);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	// configuration registers
	logic [15:0] full_cm_q, empty_dist_q;
	logic [23:0] deb_win_q, led_hp_q;
	logic [31:0] alert_to_q, off_to_q;

	// architectural state (time stamps rotate during the serial pass)
	logic         led_q, full_q, sil_q, offs_q, swst_q, swpv_q;
	logic [7:0]   ldp_q;
	logic [W-1:0] ntt_q, sct_q, ast_q, lst_q;

	// serial operands and results
	logic [W-1:0] now_sr, sum_sr, hp_sr, dbw_sr, alt_sr, oft_sr, msk_sr;
	logic         bt_q, cs_q, bs_q, ba_q, bo_q;
	logic         ge_sw_q, ge_al_q, ge_of_q, due_q;

	// word fields held for the commit
	logic         valid_q, sw_q;
	logic [7:0]   status_q;

	// percent divider
	logic [15:0]  num_q;
	logic [22:0]  rem_q;
	logic [21:0]  dvs_q;
	logic [6:0]   quo_q;
	logic         pz_q, pf_q;

	// output register
	logic         ov_q, led_o_q, buz_o_q, upd_o_q, ev_o_q, off_o_q;
	logic [6:0]   pct_o_q;

	// digit-serial arithmetic
	logic [DW:0]   t_tog, t_sum, t_sw, t_al, t_of;
	logic [DW-1:0] d_sw, d_al, d_of, mk;
	logic          ge_sw_n, ge_al_n, ge_of_n;

	always_comb begin
		mk    = msk_sr[DW-1:0];
		t_tog = {1'b0, now_sr[DW-1:0]} - {1'b0, ntt_q[DW-1:0]} - (DW+1)'(bt_q);
		t_sum = {1'b0, now_sr[DW-1:0]} + {1'b0, hp_sr[DW-1:0]} + (DW+1)'(cs_q);
		t_sw  = {1'b0, now_sr[DW-1:0]} - {1'b0, sct_q[DW-1:0]} - (DW+1)'(bs_q);
		t_al  = {1'b0, now_sr[DW-1:0]} - {1'b0, ast_q[DW-1:0]} - (DW+1)'(ba_q);
		t_of  = {1'b0, now_sr[DW-1:0]} - {1'b0, lst_q[DW-1:0]} - (DW+1)'(bo_q);
		d_sw  = t_sw[DW-1:0] & mk;
		d_al  = t_al[DW-1:0] & mk;
		d_of  = t_of[DW-1:0] & mk;
		// LSB-first magnitude compare: higher digits override
		ge_sw_n = (d_sw > dbw_sr[DW-1:0]) ? 1'b1 :
			(d_sw < dbw_sr[DW-1:0]) ? 1'b0 : ge_sw_q;
		ge_al_n = (d_al > alt_sr[DW-1:0]) ? 1'b1 :
			(d_al < alt_sr[DW-1:0]) ? 1'b0 : ge_al_q;
		ge_of_n = (d_of > oft_sr[DW-1:0]) ? 1'b1 :
			(d_of < oft_sr[DW-1:0]) ? 1'b0 : ge_of_q;
	end

	// percent result
	logic [6:0] pct_res;
	assign pct_res = pz_q ? 7'd0 : (pf_q ? PCT_FULL : quo_q);

	// commit logic, in pass order
	logic         n_led, n_full, n_sil, n_offs, n_swst, newly, changed;
	logic         deb_ge, al_ge, of_ge, upd, ev;
	logic [7:0]   n_ldp;
	logic [6:0]   pct;
	logic [W-1:0] n_ntt, n_lst, n_ast, n_sct;

	always_comb begin
		n_led  = due_q ? ~led_q : led_q;
		n_ntt  = due_q ? (sum_sr & TMASK_W) : ntt_q;
		n_lst  = lst_q;
		n_offs = offs_q;
		n_ldp  = ldp_q;
		n_full = full_q;
		n_sil  = sil_q;
		n_ast  = ast_q;
		newly  = 1'b0;
		upd    = 1'b0;
		pct    = 7'd0;
		ev     = 1'b0;
		// measurement
		if (valid_q) begin
			n_lst = now_sr;
			if (n_offs) begin
				n_offs = 1'b0;
				n_ldp  = PCT_NONE;
			end
			if (status_q == STAT_DIST) begin
				n_full = 1'b0;
				n_sil  = 1'b0;
				if ({1'b0, pct_res} != n_ldp) begin
					upd   = 1'b1;
					pct   = pct_res;
					n_ldp = {1'b0, pct_res};
				end
			end else if (status_q == STAT_FULL) begin
				if (!n_full) begin
					n_full = 1'b1;
					n_ast  = now_sr;
					newly  = 1'b1;
				end
				if (n_ldp != {1'b0, PCT_FULL}) begin
					upd   = 1'b1;
					pct   = PCT_FULL;
					n_ldp = {1'b0, PCT_FULL};
				end
			end
		end
		// button debounce; a fresh edge leaves zero elapsed time
		changed = (sw_q != swpv_q);
		n_sct   = changed ? now_sr : sct_q;
		deb_ge  = changed ? (deb_win_q == 24'd0) : ge_sw_q;
		n_swst  = swst_q;
		if (deb_ge && (swst_q != sw_q)) begin
			n_swst = sw_q;
			if (swst_q && !sw_q && n_full && !n_sil)
				n_sil = 1'b1;
		end
		// alert timeout
		al_ge = newly ? (alert_to_q == 32'd0) : ge_al_q;
		if (n_full && !n_sil && al_ge)
			n_sil = 1'b1;
		// offline check
		of_ge = valid_q ? (off_to_q == 32'd0) : ge_of_q;
		if (!n_offs && of_ge) begin
			n_offs = 1'b1;
			ev     = 1'b1;
		end
	end

	logic accept, commit;
	assign accept = in_valid && in_ready;
	assign commit = (state_q == ST_FIN) && (!ov_q || out_ready);

	// control, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			full_cm_q    <= RST_FULL_DIST;
			empty_dist_q <= RST_EMPTY_DIST;
			deb_win_q    <= RST_DEBOUNCE;
			alert_to_q   <= RST_ALERT_TO;
			off_to_q     <= RST_OFFLINE_TO;
			led_hp_q     <= RST_LED_HALF;
			led_q        <= 1'b1;
			full_q       <= 1'b0;
			sil_q        <= 1'b0;
			offs_q       <= 1'b0;
			swst_q       <= 1'b1;
			swpv_q       <= 1'b1;
			ldp_q        <= PCT_NONE;
			ntt_q        <= '0;
			sct_q        <= '0;
			ast_q        <= '0;
			lst_q        <= '0;
			ov_q         <= 1'b0;
			led_o_q      <= 1'b0;
			buz_o_q      <= 1'b0;
			upd_o_q      <= 1'b0;
			pct_o_q      <= '0;
			ev_o_q       <= 1'b0;
			off_o_q      <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FULL_DIST:  full_cm_q    <= cfg_wdata[15:0];
					REG_EMPTY_DIST: empty_dist_q <= cfg_wdata[15:0];
					REG_DEBOUNCE:   deb_win_q    <= cfg_wdata[23:0];
					REG_ALERT_TO:   alert_to_q   <= cfg_wdata;
					REG_OFFLINE_TO: off_to_q     <= cfg_wdata;
					REG_LED_HALF:   led_hp_q     <= cfg_wdata[23:0];
					default: ;
				endcase
			end

			// result taken with no new one behind it
			if (ov_q && out_ready && !commit)
				ov_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// rotate stored time stamps one digit
					ntt_q <= {ntt_q[DW-1:0], ntt_q[W-1:DW]};
					sct_q <= {sct_q[DW-1:0], sct_q[W-1:DW]};
					ast_q <= {ast_q[DW-1:0], ast_q[W-1:DW]};
					lst_q <= {lst_q[DW-1:0], lst_q[W-1:DW]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (commit) begin
						led_q   <= n_led;
						ntt_q   <= n_ntt;
						lst_q   <= n_lst;
						offs_q  <= n_offs;
						ldp_q   <= n_ldp;
						full_q  <= n_full;
						sil_q   <= n_sil;
						ast_q   <= n_ast;
						swpv_q  <= sw_q;
						sct_q   <= n_sct;
						swst_q  <= n_swst;
						ov_q    <= 1'b1;
						led_o_q <= n_led;
						buz_o_q <= n_full && !n_sil;
						upd_o_q <= upd;
						pct_o_q <= pct;
						ev_o_q  <= ev;
						off_o_q <= n_offs;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// serial datapath and divider
	always_ff @(posedge clk) begin
		if (accept) begin
			now_sr   <= W'(now_time);
			hp_sr    <= W'(led_hp_q);
			dbw_sr   <= W'(deb_win_q);
			alt_sr   <= W'(alert_to_q);
			oft_sr   <= W'(off_to_q);
			msk_sr   <= TMASK_W;
			sum_sr   <= '0;
			bt_q     <= 1'b0;
			cs_q     <= 1'b0;
			bs_q     <= 1'b0;
			ba_q     <= 1'b0;
			bo_q     <= 1'b0;
			ge_sw_q  <= 1'b1;
			ge_al_q  <= 1'b1;
			ge_of_q  <= 1'b1;
			due_q    <= 1'b0;
			valid_q  <= meas_valid;
			status_q <= meas_status;
			sw_q     <= switch_raw;
			// percent setup: range checks and operands
			pz_q     <= (empty_dist_q <= full_cm_q) || (echo_dist >= empty_dist_q);
			pf_q     <= (echo_dist < full_cm_q);
			num_q    <= empty_dist_q - echo_dist;
			dvs_q    <= {empty_dist_q - full_cm_q, 6'd0};
			quo_q    <= '0;
		end else if (state_q == ST_RUN) begin
			// one time digit per cycle
			now_sr  <= {now_sr[DW-1:0], now_sr[W-1:DW]};
			sum_sr  <= {t_sum[DW-1:0], sum_sr[W-1:DW]};
			hp_sr   <= {{DW{1'b0}}, hp_sr[W-1:DW]};
			dbw_sr  <= {{DW{1'b0}}, dbw_sr[W-1:DW]};
			alt_sr  <= {{DW{1'b0}}, alt_sr[W-1:DW]};
			oft_sr  <= {{DW{1'b0}}, oft_sr[W-1:DW]};
			msk_sr  <= {{DW{1'b0}}, msk_sr[W-1:DW]};
			bt_q    <= t_tog[DW];
			cs_q    <= t_sum[DW];
			bs_q    <= t_sw[DW];
			ba_q    <= t_al[DW];
			bo_q    <= t_of[DW];
			ge_sw_q <= ge_sw_n;
			ge_al_q <= ge_al_n;
			ge_of_q <= ge_of_n;
			// LED due when the wrapped difference has its top bit clear
			if (cnt_q == CNT_SIGN)
				due_q <= ~t_tog[SIGN_BIT];
			// divider: scale by 100 first, then one quotient bit per cycle
			if (cnt_q == '0) begin
				rem_q <= (23'(num_q) << 6) + (23'(num_q) << 5) + (23'(num_q) << 2);
			end else if (cnt_q <= DIV_LAST) begin
				if (rem_q >= {1'b0, dvs_q}) begin
					rem_q <= rem_q - {1'b0, dvs_q};
					quo_q <= {quo_q[5:0], 1'b1};
				end else begin
					quo_q <= {quo_q[5:0], 1'b0};
				end
				dvs_q <= {1'b0, dvs_q[21:1]};
			end
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = ov_q;
	assign led_on        = led_o_q;
	assign buzzer_on     = buz_o_q;
	assign gauge_update  = upd_o_q;
	assign gauge_percent = pct_o_q;
	assign offline_event = ev_o_q;
	assign offline_flag  = off_o_q;

endmodule
